// ===== rtl/sls_pkg.sv =====
// Shared types and constants for the sorted list store.
// Used by sls_ram and sorted_list_store; depends on nothing else.
package sls_pkg;

  // Field widths fixed by the interface.
  localparam int VAL_W = 32;
  localparam int POS_W = 5;
  localparam int CNT_W = 5;
  localparam int CMD_W = 3;

  // Command codes carried on in_command.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DUMP   = 3'd1,
    CMD_READ   = 3'd2,
    CMD_DELETE = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  // Status codes carried on out_status.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_NOPOS = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

endpackage

// ===== rtl/sls_ram.sv =====
// Entry memory of the sorted list store: one write port, one read port.
// Read data is registered. Depends on sls_pkg.
module sls_ram
  import sls_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                    clk,
  input  logic                    wr_en,
  input  logic [AW-1:0]           wr_addr,
  input  logic signed [VAL_W-1:0] wr_data,
  input  logic                    rd_en,
  input  logic [AW-1:0]           rd_addr,
  output logic signed [VAL_W-1:0] rd_data
);

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/sorted_list_store.sv =====
// Top level of the sorted list store: command sequencer around sls_ram.
// Depends on sls_pkg and sls_ram.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-------------------------------------------
//  input    | start, busy          | in_command, in_value, in_position
//  result   | out_valid (strobe)   | out_result_value, out_result_position,
//           |                      | out_status, out_entries_held, out_last
//
// A command is taken when start is high and busy is low. Clear, full inserts,
// bad positions and unused codes finish in the cycle they are taken, as does
// an insert into an empty store. A read goes through S_READ; other inserts
// walk down from the tail in S_INS_STEP, shifting each larger entry up, and
// write the value (in S_INS_HEAD if all are larger); a delete pulls each later
// entry down in S_DEL_STEP; a dump emits one transfer per cycle. Results are
// registered and show in the cycle after the one that produces them. The
// single memory read port is stepped one entry a cycle. Reset empties the store.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_list_store
  import sls_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [CMD_W-1:0]        in_command,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [POS_W-1:0]        in_position,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_result_value,
  output logic [POS_W-1:0]        out_result_position,
  output logic [1:0]              out_status,
  output logic [CNT_W-1:0]        out_entries_held,
  output logic                    out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_STEP,
    S_INS_HEAD,
    S_DEL_STEP,
    S_DUMP,
    S_READ
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [AW-1:0]           idx_r, idx_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [POS_W-1:0]        pos_r, pos_nxt;

  logic                    ov_r, ov_nxt;
  logic signed [VAL_W-1:0] oval_r, oval_nxt;
  logic [POS_W-1:0]        opos_r, opos_nxt;
  status_t                 ost_r, ost_nxt;
  logic                    olast_r, olast_nxt;

  logic                    wr_en, rd_en;
  logic [AW-1:0]           wr_addr, rd_addr;
  logic signed [VAL_W-1:0] wr_data, rd_data;

  logic [CW-1:0]           idx_inc;
  logic [XW-1:0]           pos_x, cnt_x;

  assign idx_inc = CW'(idx_r) + 1'b1;
  assign pos_x   = XW'(in_position);
  assign cnt_x   = XW'(count_r);

  // Entry memory. The shift loops always write two slots away from the slot
  // they read in the same cycle, so a read never meets a write to the same entry.
  sls_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next-state logic and memory control.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    pos_nxt   = pos_r;
    ov_nxt    = 1'b0;
    oval_nxt  = '0;
    opos_nxt  = '0;
    ost_nxt   = ST_OK;
    olast_nxt = 1'b1;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = '0;
    rd_en     = 1'b0;
    rd_addr   = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          val_nxt = in_value;
          pos_nxt = in_position;
          case (cmd_t'(in_command))
            CMD_INSERT: begin
              if (count_r >= CW'(DEPTH)) begin
                ov_nxt  = 1'b1;
                ost_nxt = ST_FULL;
              end else if (count_r == '0) begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = in_value;
                count_nxt = count_r + 1'b1;
                ov_nxt    = 1'b1;
              end else begin
                // Walk down from the tail, shifting larger entries up.
                rd_en     = 1'b1;
                rd_addr   = AW'(count_r - 1'b1);
                idx_nxt   = AW'(count_r - 1'b1);
                state_nxt = S_INS_STEP;
              end
            end
            CMD_DUMP: begin
              if (count_r == '0) begin
                ov_nxt  = 1'b1;
                ost_nxt = ST_EMPTY;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                idx_nxt   = '0;
                state_nxt = S_DUMP;
              end
            end
            CMD_READ, CMD_DELETE: begin
              if (count_r == '0) begin
                ov_nxt  = 1'b1;
                ost_nxt = ST_EMPTY;
              end else if (in_position == '0 || pos_x > cnt_x) begin
                ov_nxt  = 1'b1;
                ost_nxt = ST_NOPOS;
              end else if (cmd_t'(in_command) == CMD_READ) begin
                rd_en     = 1'b1;
                rd_addr   = AW'(in_position - 1'b1);
                state_nxt = S_READ;
              end else if (pos_x == cnt_x) begin
                // Deleting the tail entry moves nothing.
                count_nxt = count_r - 1'b1;
                ov_nxt    = 1'b1;
              end else begin
                // Pull each later entry one slot down.
                rd_en     = 1'b1;
                rd_addr   = AW'(in_position);
                idx_nxt   = AW'(in_position);
                state_nxt = S_DEL_STEP;
              end
            end
            CMD_CLEAR: begin
              count_nxt = '0;
              ov_nxt    = 1'b1;
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end

      S_INS_STEP: begin
        wr_en   = 1'b1;
        wr_addr = AW'(idx_inc);
        if (rd_data > val_r) begin
          wr_data = rd_data;
          if (idx_r == '0) begin
            state_nxt = S_INS_HEAD;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r - 1'b1;
            idx_nxt = idx_r - 1'b1;
          end
        end else begin
          wr_data   = val_r;
          count_nxt = count_r + 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_INS_HEAD: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = val_r;
        count_nxt = count_r + 1'b1;
        ov_nxt    = 1'b1;
        state_nxt = S_IDLE;
      end

      S_DEL_STEP: begin
        wr_en   = 1'b1;
        wr_addr = idx_r - 1'b1;
        wr_data = rd_data;
        if (idx_inc == count_r) begin
          count_nxt = count_r - 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_inc);
          idx_nxt = AW'(idx_inc);
        end
      end

      S_DUMP: begin
        ov_nxt    = 1'b1;
        oval_nxt  = rd_data;
        opos_nxt  = POS_W'(idx_inc);
        olast_nxt = (idx_inc == count_r);
        if (idx_inc == count_r) begin
          state_nxt = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = AW'(idx_inc);
          idx_nxt = AW'(idx_inc);
        end
      end

      S_READ: begin
        ov_nxt    = 1'b1;
        oval_nxt  = rd_data;
        opos_nxt  = pos_r;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State, entry count and registered result transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
    idx_r   <= idx_nxt;
    val_r   <= val_nxt;
    pos_r   <= pos_nxt;
    oval_r  <= oval_nxt;
    opos_r  <= opos_nxt;
    ost_r   <= ost_nxt;
    olast_r <= olast_nxt;
  end

  // The entry count shown with a result is the count after the command.
  assign busy                = (state_r != S_IDLE);
  assign out_valid           = ov_r;
  assign out_result_value    = oval_r;
  assign out_result_position = opos_r;
  assign out_status          = ost_r;
  assign out_entries_held    = CNT_W'(count_r);
  assign out_last            = olast_r;

endmodule
